// File: src/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg - shared definitions for the sorted priority queue
// Sequencer state codes, action codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SHIFT,
        ST_PLACE,
        ST_POLL,
        ST_FIN
    } spq_state_t;

    typedef logic [1:0] spq_status_t;

    localparam logic        ACT_INSERT = 1'b0;
    localparam logic        ACT_POLL   = 1'b1;

    localparam spq_status_t STAT_OK    = 2'd0;
    localparam spq_status_t STAT_FULL  = 2'd1;
    localparam spq_status_t STAT_EMPTY = 2'd2;

endpackage

`default_nettype wire

// File: src/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store - circular entry store
// Entry RAM addressed relative to the current head. One write and one
// registered read per cycle; relative indices wrap around DEPTH.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_store
    import spq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic [$clog2(DEPTH)-1:0] head,
    input  wire logic [$clog2(DEPTH)-1:0] rd_rel,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_rel,
    input  wire logic [WIDTH-1:0]         wr_data,
    output logic      [WIDTH-1:0]         rd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W:0] DEPTH_X = (IDX_W+1)'(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];

    logic [IDX_W:0]   rd_sum;
    logic [IDX_W:0]   wr_sum;
    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;

    // head + rel, folded back once past the end of the ring
    always_comb begin
        rd_sum = {1'b0, head} + {1'b0, rd_rel};
        wr_sum = {1'b0, head} + {1'b0, wr_rel};
        if (rd_sum >= DEPTH_X) begin
            rd_sum = rd_sum - DEPTH_X;
        end
        if (wr_sum >= DEPTH_X) begin
            wr_sum = wr_sum - DEPTH_X;
        end
        rd_addr = rd_sum[IDX_W-1:0];
        wr_addr = wr_sum[IDX_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: src/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue - sorted array priority queue
// Holds up to DEPTH key/payload entries in ascending key order; equal keys
// leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_*: s_tuser selects insert (0) or poll (1), s_tdata
//   carries key and payload. Every beat yields exactly one result beat on
//   m_*: m_tuser is the status (ok, full, empty), m_tdata holds the polled
//   key and payload (zero otherwise) and the occupancy after the operation.
//   Entries sit in a ring-addressed RAM; a poll just advances the head.
//   An insert walks down from the tail, one entry per cycle, moving each
//   larger entry up one slot until the insert position is found.
//   Sequence: poll ST_POLL, ST_FIN; insert ST_SHIFT (while larger keys
//   remain, empty queue skips it), ST_PLACE or a last ST_SHIFT write, ST_FIN;
//   refused insert or empty poll ST_FIN only. ST_FIN loads the result once
//   the output register is free; s_tready rises together with m_tvalid.
//   One item is worked on at a time, so the rate is set by that single-port
//   insertion walk; s_tready is high only while the sequencer is idle.
//   The result sits in an output register; a new item is taken while it
//   waits, but the next result holds until m_tready frees the register.
//   Reset (aresetn low, synchronous) empties the queue; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH        = 64,
    parameter int PAYLOAD_BITS = 32,
    parameter int KEY_BITS     = 32
) (
    input  wire logic aclk,
    input  wire logic aresetn,

    input  wire logic s_tvalid,
    output logic      s_tready,
    // [KEY_BITS-1:0] key, then payload, zero padded to bytes
    input  wire logic [((KEY_BITS+PAYLOAD_BITS+7)/8)*8-1:0] s_tdata,
    // [0] action
    input  wire logic s_tuser,

    output logic      m_tvalid,
    input  wire logic m_tready,
    // [KEY_BITS-1:0] out_key, then out_payload, then occupancy, zero padded
    output logic [((KEY_BITS+PAYLOAD_BITS+$clog2(DEPTH+1)+7)/8)*8-1:0] m_tdata,
    // [1:0] status
    output logic [1:0] m_tuser
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH+1);
    localparam int ENT_W  = KEY_BITS + PAYLOAD_BITS;
    localparam int MDAT_W = ((ENT_W + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    spq_state_t state_reg, state_next;

    logic [CNT_W-1:0]        count_reg, count_next;
    logic [IDX_W-1:0]        head_reg, head_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [KEY_BITS-1:0]     key_reg, key_next;
    logic [PAYLOAD_BITS-1:0] pay_reg, pay_next;
    spq_status_t             status_reg, status_next;
    logic [KEY_BITS-1:0]     rkey_reg, rkey_next;
    logic [PAYLOAD_BITS-1:0] rpay_reg, rpay_next;

    logic                    m_valid_reg, m_valid_next;
    spq_status_t             m_status_reg, m_status_next;
    logic [KEY_BITS-1:0]     m_key_reg, m_key_next;
    logic [PAYLOAD_BITS-1:0] m_pay_reg, m_pay_next;
    logic [CNT_W-1:0]        m_occ_reg, m_occ_next;

    logic [IDX_W-1:0] rd_rel;
    logic             wr_en;
    logic [IDX_W-1:0] wr_rel;
    logic [ENT_W-1:0] wr_data;
    logic [ENT_W-1:0] rd_data;

    logic [KEY_BITS-1:0]     rd_key;
    logic [PAYLOAD_BITS-1:0] rd_pay;

    assign rd_key = rd_data[KEY_BITS-1:0];
    assign rd_pay = rd_data[ENT_W-1:KEY_BITS];

    spq_store #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_store (
        .aclk    (aclk),
        .head    (head_reg),
        .rd_rel  (rd_rel),
        .wr_en   (wr_en),
        .wr_rel  (wr_rel),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = MDAT_W'({m_occ_reg, m_pay_reg, m_key_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            head_reg    <= head_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        key_reg      <= key_next;
        pay_reg      <= pay_next;
        status_reg   <= status_next;
        rkey_reg     <= rkey_next;
        rpay_reg     <= rpay_next;
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_pay_reg    <= m_pay_next;
        m_occ_reg    <= m_occ_next;
    end

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        head_next     = head_reg;
        pos_next      = pos_reg;
        key_next      = key_reg;
        pay_next      = pay_reg;
        status_next   = status_reg;
        rkey_next     = rkey_reg;
        rpay_next     = rpay_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_pay_next    = m_pay_reg;
        m_occ_next    = m_occ_reg;
        rd_rel        = pos_reg - IDX_W'(2);
        wr_en         = 1'b0;
        wr_rel        = pos_reg;
        wr_data       = {pay_reg, key_reg};

        case (state_reg)
            ST_IDLE: begin
                rd_rel = '0;
                if (s_tvalid) begin
                    key_next    = s_tdata[KEY_BITS-1:0];
                    pay_next    = s_tdata[ENT_W-1:KEY_BITS];
                    status_next = STAT_OK;
                    rkey_next   = '0;
                    rpay_next   = '0;
                    if (s_tuser == ACT_POLL) begin
                        if (count_reg == '0) begin
                            status_next = STAT_EMPTY;
                            state_next  = ST_FIN;
                        end else begin
                            state_next = ST_POLL;
                        end
                    end else if (count_reg == FULL_CNT) begin
                        status_next = STAT_FULL;
                        state_next  = ST_FIN;
                    end else if (count_reg == '0) begin
                        pos_next   = '0;
                        state_next = ST_PLACE;
                    end else begin
                        // start the walk at the tail entry
                        pos_next   = count_reg[IDX_W-1:0];
                        rd_rel     = count_reg[IDX_W-1:0] - IDX_W'(1);
                        state_next = ST_SHIFT;
                    end
                end
            end

            ST_SHIFT: begin
                // rd_data holds entry pos-1; the read of pos-2 is issued now
                wr_en = 1'b1;
                if (rd_key > key_reg) begin
                    wr_data  = rd_data;
                    pos_next = pos_reg - IDX_W'(1);
                    if (pos_reg == IDX_W'(1)) begin
                        state_next = ST_PLACE;
                    end
                end else begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_FIN;
                end
            end

            ST_PLACE: begin
                wr_en      = 1'b1;
                count_next = count_reg + CNT_W'(1);
                state_next = ST_FIN;
            end

            ST_POLL: begin
                rkey_next  = rd_key;
                rpay_next  = rd_pay;
                head_next  = (head_reg == LAST_IDX) ? '0 : head_reg + IDX_W'(1);
                count_next = count_reg - CNT_W'(1);
                state_next = ST_FIN;
            end

            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_key_next    = rkey_reg;
                    m_pay_next    = rpay_reg;
                    m_occ_next    = count_reg;
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("entry count beyond DEPTH");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == STAT_FULL) |-> (m_occ_reg == FULL_CNT))
        else $error("full status with queue not full");

    a_poll_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_POLL) |=> (count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("poll did not remove one entry");

    a_shift_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SHIFT) |-> (pos_reg != '0 && count_reg != FULL_CNT))
        else $error("insertion walk out of range");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - self-checking bench for sorted_priority_queue
// Sends insert and poll beats and keeps a sorted shadow array. Each result
// beat is checked against the oldest predicted result: status, polled key,
// polled payload and occupancy. Random phases fill the queue past full,
// drain it past empty and mix both, with idle gaps and stalls on both sides.
// ----------------------------------------------------------------------------

module tb;
    import spq_pkg::*;

    localparam int DEPTH = 64;

    typedef struct packed {
        logic        act;
        logic [31:0] key;
        logic [31:0] pay;
        logic        hold;   // wait for all results before sending
    } queue_op_t;

    typedef struct packed {
        spq_status_t status;
        logic [31:0] key;
        logic [31:0] pay;
        logic [6:0]  occ;
    } queue_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;   // [31:0] key, [63:32] payload
    logic        s_tuser  = ACT_INSERT;   // [0] action
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;   // [31:0] out_key, [63:32] out_payload, [70:64] occupancy
    logic [1:0]  m_tuser;   // [1:0] status

    queue_op_t     op_queue[$];
    queue_result_t awaited[$];

    // shadow of the sorted store
    logic [31:0] shadow_keys[DEPTH];
    logic [31:0] shadow_pays[DEPTH];
    int          shadow_count;

    int  error_count    = 0;
    int  accepted_count = 0;
    int  total_ops      = 0;
    int  gen_count      = 0;
    bit  in_fire        = 1'b0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  send_calm      = 1'b0;
    bit  recv_calm      = 1'b0;

    sorted_priority_queue u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // one insert or poll on the shadow store, returns the predicted result
    function automatic queue_result_t apply_queue_op(input queue_op_t op);
        queue_result_t res;
        int pos;
        res = '0;
        res.status = STAT_OK;
        if (op.act == ACT_INSERT) begin
            if (shadow_count >= DEPTH) begin
                res.status = STAT_FULL;
            end else begin
                pos = shadow_count;
                while (pos > 0 && shadow_keys[pos-1] > op.key) begin
                    shadow_keys[pos] = shadow_keys[pos-1];
                    shadow_pays[pos] = shadow_pays[pos-1];
                    pos--;
                end
                shadow_keys[pos] = op.key;
                shadow_pays[pos] = op.pay;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = STAT_EMPTY;
            end else begin
                res.key = shadow_keys[0];
                res.pay = shadow_pays[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_keys[i-1] = shadow_keys[i];
                    shadow_pays[i-1] = shadow_pays[i];
                end
                shadow_count--;
            end
        end
        res.occ = shadow_count[6:0];
        return res;
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // mostly full range; some narrow ranges for equal keys, some extremes
    function automatic logic [31:0] pick_key(input int mode);
        case (mode)
            0: begin
                return $urandom_range(0, 7);
            end
            1: begin
                case ($urandom_range(0, 2))
                    0: return 32'h0;
                    1: return 32'hFFFF_FFFF;
                    default: return $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
                endcase
            end
            default: begin
                return $urandom;
            end
        endcase
    endfunction

    task automatic queue_op(input logic act, input logic [31:0] key,
                            input logic [31:0] pay, input logic hold);
        queue_op_t op;
        op.act  = act;
        op.key  = key;
        op.pay  = pay;
        op.hold = hold;
        op_queue.push_back(op);
        total_ops++;
        if (act == ACT_INSERT && gen_count < DEPTH) gen_count++;
        if (act == ACT_POLL && gen_count > 0) gen_count--;
    endtask

    task automatic queue_random_insert(input int key_mode, input logic hold);
        queue_op(ACT_INSERT, pick_key(key_mode), $urandom, hold);
    endtask

    // input side: predict on every accepted beat
    always @(posedge aclk) begin
        queue_op_t op;
        in_fire = aresetn && s_tvalid && s_tready;
        if (in_fire) begin
            op.act  = s_tuser;
            op.key  = s_tdata[31:0];
            op.pay  = s_tdata[63:32];
            op.hold = 1'b0;
            awaited.push_back(apply_queue_op(op));
            accepted_count++;
        end
    end

    // result side
    always @(posedge aclk) begin
        queue_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited.size() == 0) begin
                $display("[%0t] result beat with nothing expected", $realtime);
                error_count++;
            end else begin
                want = awaited.pop_front();
                if (m_tuser != want.status)
                    flag_mismatch("status", 32'(m_tuser), 32'(want.status));
                if (m_tdata[31:0] != want.key)
                    flag_mismatch("out_key", m_tdata[31:0], want.key);
                if (m_tdata[63:32] != want.pay)
                    flag_mismatch("out_payload", m_tdata[63:32], want.pay);
                if (m_tdata[70:64] != want.occ)
                    flag_mismatch("occupancy", 32'(m_tdata[70:64]), 32'(want.occ));
            end
        end
    end

    // input driver
    always @(negedge aclk) begin
        queue_op_t op;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_fire) begin
            // beat still waiting for s_tready
        end else if (send_gap > 0) begin
            s_tvalid <= 1'b0;
            send_gap--;
        end else if (op_queue.size() != 0 && (!op_queue[0].hold || awaited.size() == 0)) begin
            op = op_queue.pop_front();
            s_tvalid <= 1'b1;
            s_tuser  <= op.act;
            s_tdata  <= {op.pay, op.key};
            if ($urandom_range(0, 79) == 0) send_calm = !send_calm;
            send_gap = pick_gap(send_calm);
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result side backpressure
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            if ($urandom_range(0, 149) == 0) recv_calm = !recv_calm;
            if (!recv_calm && $urandom_range(0, 9) == 0) begin
                stall_left = pick_gap(1'b0);
                m_tready <= (stall_left == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        int phase;
        int len;
        int key_mode;
        int insert_pct;
        logic hold;

        shadow_count = 0;
        for (int i = 0; i < DEPTH; i++) begin
            shadow_keys[i] = '0;
            shadow_pays[i] = '0;
        end

        // directed: empty poll, extreme keys and payloads, equal keys in order
        queue_op(ACT_POLL,   32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
        queue_op(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
        queue_op(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_op(ACT_INSERT, 32'h0000_0005, 32'h0000_000A, 1'b0);
        queue_op(ACT_INSERT, 32'h0000_0005, 32'h0000_000B, 1'b0);
        queue_op(ACT_INSERT, 32'h8000_0000, 32'h5555_5555, 1'b0);
        queue_op(ACT_INSERT, 32'h0000_0005, 32'h0000_000C, 1'b0);
        queue_op(ACT_INSERT, 32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b0);
        queue_op(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        queue_op(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFE, 1'b0);
        for (int i = 0; i < 9; i++) queue_op(ACT_POLL, 32'h0, 32'h0, 1'b0);
        queue_op(ACT_POLL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        queue_op(ACT_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        queue_op(ACT_POLL,   32'h0, 32'h0, 1'b0);

        // random phases: fill past full, drain past empty, mixed traffic
        phase = 1;
        while (total_ops < 1220) begin
            key_mode = $urandom_range(0, 5);
            hold = ($urandom_range(0, 3) == 0);
            case (phase)
                1: begin
                    while (gen_count < DEPTH) begin
                        queue_random_insert(key_mode, hold);
                        hold = 1'b0;
                    end
                    len = $urandom_range(1, 3);
                    for (int i = 0; i < len; i++) queue_random_insert(key_mode, 1'b0);
                end
                2: begin
                    while (gen_count > 0) begin
                        queue_op(ACT_POLL, $urandom, $urandom, hold);
                        hold = 1'b0;
                    end
                    len = $urandom_range(1, 2);
                    for (int i = 0; i < len; i++) queue_op(ACT_POLL, $urandom, $urandom, 1'b0);
                end
                default: begin
                    insert_pct = (phase == 3) ? 75 : 50;
                    len = $urandom_range(20, 80);
                    for (int i = 0; i < len; i++) begin
                        if ($urandom_range(0, 99) < insert_pct)
                            queue_random_insert(key_mode, hold);
                        else
                            queue_op(ACT_POLL, $urandom, $urandom, hold);
                        hold = 1'b0;
                    end
                end
            endcase
            phase = $urandom_range(0, 3);
        end

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk); while (accepted_count < total_ops || awaited.size() != 0);
        repeat (100) @(posedge aclk);
        @(negedge aclk);
        if (awaited.size() != 0) begin
            $display("%0d predicted results never arrived", awaited.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("timeout: %0d of %0d beats accepted", accepted_count, total_ops);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// File: files.f
src/spq_pkg.sv
src/spq_store.sv
src/sorted_priority_queue.sv
tb/tb.sv
